[rtl/postfix_stack_calculator_defines.svh]
// Assertion macros shared by the postfix stack calculator RTL.
`ifndef POSTFIX_STACK_CALCULATOR_DEFINES_SVH
`define POSTFIX_STACK_CALCULATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored while reset is active.
`define PSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and ignored while reset is active.
`define PSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pscalc_pkg.sv]
// Shared types, codes and command structures for the postfix stack calculator.
`default_nettype none

package pscalc_pkg;

    localparam int DATA_W            = 32;
    localparam int OP_W              = 3;
    localparam int STAT_W            = 2;
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int DIV_STEPS         = DATA_W;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

    typedef logic [OP_W-1:0]   op_code_t;
    typedef logic [STAT_W-1:0] stat_code_t;

    localparam op_code_t OP_PUSH = 3'd0;
    localparam op_code_t OP_ADD  = 3'd1;
    localparam op_code_t OP_SUB  = 3'd2;
    localparam op_code_t OP_NEG  = 3'd3;
    localparam op_code_t OP_MUL  = 3'd4;
    localparam op_code_t OP_DIV  = 3'd5;

    localparam stat_code_t STAT_OK      = 2'd0;
    localparam stat_code_t STAT_UNDER   = 2'd1;
    localparam stat_code_t STAT_OVER    = 2'd2;
    localparam stat_code_t STAT_DIVZERO = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_MUL,
        S_DIV,
        S_RESULT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       do_push;
        logic       do_neg;
        logic       rd_issue;
        logic       mul_start;
        logic       div_start;
        logic       pop_commit;
        logic       set_status;
        stat_code_t status_code;
        logic       out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_code_t op;
        logic     count_zero;
        logic     count_lt2;
        logic     count_full;
        logic     top_zero;
        logic     div_done;
    } dp_sts_t;

endpackage

`default_nettype wire

[rtl/pscalc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pscalc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/pscalc_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module pscalc_div
    import pscalc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic      [DATA_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    dmag_reg;
    logic                 qneg_reg;

    logic [DATA_W:0]      rem_shift;
    logic [DATA_W:0]      rem_diff;
    logic                 fits;
    logic [DATA_W-1:0]    rem_next;
    logic [DATA_W-1:0]    quo_next;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DATA_W-1]};
        rem_diff  = rem_shift - {1'b0, dmag_reg};
        fits      = (rem_shift >= {1'b0, dmag_reg});
        rem_next  = fits ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
        quo_next  = {quo_reg[DATA_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            dmag_reg <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            qneg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = qneg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

`default_nettype wire

[rtl/pscalc_ctrl.sv]
// Controller state machine that sequences each token through the datapath.
`default_nettype none

module pscalc_ctrl
    import pscalc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        decode_ok;

    assign out_free = !out_valid_reg || !out_stall;

    // A binary operator goes to the operand fetch only when it raises no error.
    always_comb
    begin
        decode_ok = !sts.count_lt2 && !((sts.op == OP_DIV) && sts.top_zero);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.op) inside
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                        state_next = decode_ok ? S_FETCH : S_RESULT;
                    default:
                        state_next = S_RESULT;
                endcase
            end
            S_FETCH:
            begin
                unique case (sts.op) inside
                    OP_MUL:  state_next = S_MUL;
                    OP_DIV:  state_next = S_DIV;
                    default: state_next = S_RESULT;
                endcase
            end
            S_MUL:
            begin
                state_next = S_RESULT;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
            end
            S_DECODE:
            begin
                unique case (sts.op) inside
                    OP_PUSH:
                    begin
                        if (sts.count_full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STAT_OVER;
                        end
                        else
                        begin
                            cmd.do_push = 1'b1;
                        end
                    end
                    OP_NEG:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STAT_UNDER;
                        end
                        else
                        begin
                            cmd.do_neg = 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    begin
                        if (sts.count_lt2)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STAT_UNDER;
                        end
                        else if ((sts.op == OP_DIV) && sts.top_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STAT_DIVZERO;
                        end
                        else
                        begin
                            cmd.rd_issue = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.set_status = 1'b0;
                    end
                endcase
            end
            S_FETCH:
            begin
                unique case (sts.op) inside
                    OP_MUL:  cmd.mul_start  = 1'b1;
                    OP_DIV:  cmd.div_start  = 1'b1;
                    default: cmd.pop_commit = 1'b1;
                endcase
            end
            S_MUL:
            begin
                cmd.pop_commit = 1'b1;
            end
            S_DIV:
            begin
                cmd.pop_commit = sts.div_done;
            end
            S_RESULT:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/pscalc_dp.sv]
// Datapath: top-of-stack register, stack RAM, arithmetic units and result register.
`default_nettype none

module pscalc_dp
    import pscalc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dp_cmd_t                  cmd,
    output dp_sts_t                       sts,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic signed [DATA_W-1:0] push_value,
    output logic signed [DATA_W-1:0]      top_value,
    output logic                          stack_empty,
    output logic [STAT_W-1:0]             status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // The top entry lives in top_reg; the entries below it live in the RAM.
    logic [CW-1:0]     count_reg;
    logic [DATA_W-1:0] top_reg;
    op_code_t          op_reg;
    logic [DATA_W-1:0] val_reg;
    stat_code_t        status_reg;
    logic [DATA_W-1:0] prod_reg;

    logic [DATA_W-1:0] out_top_reg;
    logic              out_empty_reg;
    stat_code_t        out_status_reg;

    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic [DATA_W-1:0] sec_data;
    logic [DATA_W-1:0] product;
    logic [DATA_W-1:0] div_q;
    logic              div_done;
    logic [DATA_W-1:0] pop_result;
    logic              count_zero;

    assign cnt_m1     = count_reg - CW'(1);
    assign cnt_m2     = count_reg - CW'(2);
    assign count_zero = (count_reg == '0);

    pscalc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (cmd.do_push && !count_zero),
        .wr_addr (cnt_m1[AW-1:0]),
        .wr_data (top_reg),
        .rd_en   (cmd.rd_issue),
        .rd_addr (cnt_m2[AW-1:0]),
        .rd_data (sec_data)
    );

    pscalc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sec_data),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign product = sec_data * top_reg;

    always_comb
    begin
        case (op_reg)
            OP_ADD:  pop_result = sec_data + top_reg;
            OP_SUB:  pop_result = sec_data - top_reg;
            OP_MUL:  pop_result = prod_reg;
            default: pop_result = div_q;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.do_push)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (cmd.pop_commit)
        begin
            count_reg <= cnt_m1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= operation;
            val_reg    <= $unsigned(push_value);
            status_reg <= STAT_OK;
        end
        else if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end

        if (cmd.do_push)
        begin
            top_reg <= val_reg;
        end
        else if (cmd.do_neg)
        begin
            top_reg <= DATA_W'(0) - top_reg;
        end
        else if (cmd.pop_commit)
        begin
            top_reg <= pop_result;
        end

        if (cmd.mul_start)
        begin
            prod_reg <= product;
        end

        if (cmd.out_load)
        begin
            out_top_reg    <= count_zero ? '0 : top_reg;
            out_empty_reg  <= count_zero;
            out_status_reg <= status_reg;
        end
    end

    always_comb
    begin
        sts.op         = op_reg;
        sts.count_zero = count_zero;
        sts.count_lt2  = (count_reg < CW'(2));
        sts.count_full = (count_reg == CW'(STACK_DEPTH));
        sts.top_zero   = (top_reg == '0);
        sts.div_done   = div_done;
    end

    assign top_value   = $signed(out_top_reg);
    assign stack_empty = out_empty_reg;
    assign status      = out_status_reg;

endmodule

`default_nettype wire

[rtl/postfix_stack_calculator.sv]
// Top level of the reverse-Polish integer stack calculator.
//
// Usage: each input item on in_valid/in_stall is one token: operation selects push, add,
// subtract, negate, multiply or divide, and push_value is the operand of a push. Every
// accepted item gives exactly one result item on out_valid/out_stall with the new top of
// the stack (zero when empty), an empty flag and a status (ok, underflow, overflow or
// divide by zero). A token that raises an error leaves the stack untouched.
// The block works on one item at a time. Divide uses the shift-subtract divider, which
// retires one quotient bit per cycle. A new item is taken in the cycle after its
// predecessor's result is loaded into the output register, so results and new items
// overlap.
// Reset clears the entry count, the controller and the output valid; the stack RAM is not
// cleared and needs no clearing pass, since no entry is read before it is written.
// While the receiver stalls, the result stays in the output register; the block still
// accepts one more item and holds its result internally until the register frees up.
`default_nettype none
`include "postfix_stack_calculator_defines.svh"

module postfix_stack_calculator
    import pscalc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic signed [DATA_W-1:0] push_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      top_value,
    output logic                          stack_empty,
    output logic [STAT_W-1:0]             status
);

    // The controller and datapath talk only through these two bundles.
    dp_cmd_t cmd;
    dp_sts_t sts;

    pscalc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath keeps the top entry in a register so that each binary operator
    // needs only one RAM read for the entry beneath it.
    pscalc_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .operation   (operation),
        .push_value  (push_value),
        .top_value   (top_value),
        .stack_empty (stack_empty),
        .status      (status)
    );

    // Once an item is taken, the block must be busy with it on the next cycle.
    `PSC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "input accepted but block did not go busy")

    // An empty stack always reports a zero top value.
    `PSC_ASSERT_NOW(a_empty_top_zero, out_valid && stack_empty, top_value == '0,
        "empty stack reported with nonzero top value")

    // Divide by zero can only be flagged with at least two entries on the stack.
    `PSC_ASSERT_NOW(a_divzero_not_empty, out_valid && (status == STAT_DIVZERO), !stack_empty,
        "divide by zero reported on an empty stack")

    // Overflow can only occur with a full, hence non-empty, stack.
    `PSC_ASSERT_NOW(a_over_not_empty, out_valid && (status == STAT_OVER), !stack_empty,
        "overflow reported on an empty stack")

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the postfix stack calculator: directed and random token streams.
`timescale 1ns / 1ps

module tb_top
    import pscalc_pkg::*;
();

    // The bench runs the block at its default depth and keeps its own stack of that size.
    localparam int CALC_DEPTH     = STACK_DEPTH_DEF;
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 3;
    localparam int RANDOM_ITEMS   = 1000;
    // Allow for the slowest token, the longest sender gap and the longest receiver
    // stall, then leave a wide margin before calling the run hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Drain time after the last result, longer than the slowest token.
    localparam int TAIL_CYCLES    = 50;

    // The two operation codes that the block ignores.
    localparam op_code_t OP_SPARE_LO = 3'd6;
    localparam op_code_t OP_SPARE_HI = 3'd7;

    localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

    typedef struct {
        op_code_t          op;
        logic [DATA_W-1:0] value;
    } token_t;

    typedef struct {
        logic [DATA_W-1:0] top;
        logic              empty;
        stat_code_t        stat;
    } calc_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          operation = '0;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] top_value;
    logic                     stack_empty;
    logic [STAT_W-1:0]        status;

    // Tokens waiting to be driven, and the results that accepted tokens still owe.
    token_t       token_queue[$];
    calc_result_t expected_results[$];

    // The bench's own copy of the operand stack, advanced once per accepted token.
    logic [DATA_W-1:0] calc_stack[CALC_DEPTH];
    int                calc_depth = 0;

    // Rough stack depth seen by the stimulus generator. It is only used to shape
    // the stream, so it may drift after a divide by zero that it did not foresee.
    int          est_depth = 0;

    int          mismatch_count = 0;
    int          idle_cycles = 0;
    logic        timed_out = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_hold = 0;
    logic        tx_quiet = 1'b0;
    logic        rx_quiet = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    postfix_stack_calculator #(
        .STACK_DEPTH(CALC_DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .top_value  (top_value),
        .stack_empty(stack_empty),
        .status     (status)
    );

    // Signed division by magnitudes, so that the most negative value over minus one
    // wraps back to itself instead of depending on the simulator.
    function automatic logic [DATA_W-1:0] quotient_toward_zero(
        input logic [DATA_W-1:0] num,
        input logic [DATA_W-1:0] den
    );
        logic [DATA_W-1:0] num_mag;
        logic [DATA_W-1:0] den_mag;
        logic [DATA_W-1:0] quo;
        num_mag = num[DATA_W-1] ? -num : num;
        den_mag = den[DATA_W-1] ? -den : den;
        quo = num_mag / den_mag;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quo : quo;
    endfunction

    // Applies one token to the bench's stack and records the result it must produce.
    // Every error leaves the stack as it was; the spare codes change nothing at all.
    task automatic apply_token(input op_code_t op, input logic [DATA_W-1:0] value);
        calc_result_t      res;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] sec;
        logic [DATA_W-1:0] folded;
        res.stat = STAT_OK;
        case (op)
            OP_PUSH:
            begin
                if (calc_depth >= CALC_DEPTH)
                begin
                    res.stat = STAT_OVER;
                end
                else
                begin
                    calc_stack[calc_depth] = value;
                    calc_depth++;
                end
            end
            OP_NEG:
            begin
                if (calc_depth < 1)
                begin
                    res.stat = STAT_UNDER;
                end
                else
                begin
                    calc_stack[calc_depth-1] = -calc_stack[calc_depth-1];
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
            begin
                if (calc_depth < 2)
                begin
                    res.stat = STAT_UNDER;
                end
                else
                begin
                    top = calc_stack[calc_depth-1];
                    sec = calc_stack[calc_depth-2];
                    if (op == OP_DIV && top == '0)
                    begin
                        res.stat = STAT_DIVZERO;
                    end
                    else
                    begin
                        case (op)
                            OP_ADD:  folded = sec + top;
                            OP_SUB:  folded = sec - top;
                            OP_MUL:  folded = sec * top;
                            default: folded = quotient_toward_zero(sec, top);
                        endcase
                        calc_depth--;
                        calc_stack[calc_depth-1] = folded;
                    end
                end
            end
            default: ;
        endcase
        res.top   = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
        res.empty = (calc_depth == 0);
        expected_results.push_back(res);
    endtask

    // Gap or stall length: mostly none, some short, a few long, and none at all
    // while that side is in a quiet stretch.
    function automatic int unsigned idle_len(input logic quiet);
        int unsigned roll;
        if (quiet)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            return 0;
        end
        else if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Operands lean on the extremes and on small values, so that divisions give
    // quotients other than zero and minus one; the rest use every bit at random.
    function automatic logic [DATA_W-1:0] random_operand();
        case ($urandom_range(0, 9))
            0, 1:
                case ($urandom_range(0, 6))
                    0:       return '0;
                    1:       return 32'd1;
                    2:       return MINUS_ONE;
                    3:       return MOST_NEG;
                    4:       return MOST_POS;
                    5:       return 32'd2;
                    default: return -32'sd2;
                endcase
            2, 3, 4: return 32'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    function automatic op_code_t random_binary_op();
        case ($urandom_range(0, 3))
            0:       return OP_ADD;
            1:       return OP_SUB;
            2:       return OP_MUL;
            default: return OP_DIV;
        endcase
    endfunction

    task automatic queue_token(input op_code_t op, input logic [DATA_W-1:0] value);
        token_t tok;
        tok.op = op;
        tok.value = value;
        token_queue.push_back(tok);
        if (op == OP_PUSH && est_depth < CALC_DEPTH)
        begin
            est_depth++;
        end
        else if ((op == OP_ADD || op == OP_SUB || op == OP_MUL || op == OP_DIV)
                 && est_depth >= 2)
        begin
            est_depth--;
        end
    endtask

    // Driver: presents the next token once the current one is taken, with a random
    // gap after each. The payload stays put until the block accepts it.
    always @(posedge clk)
    begin : token_driver
        token_t tok;
        logic   item_taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            item_taken = in_valid && !in_stall;
            if (item_taken)
            begin
                apply_token(operation, push_value);
            end
            if (!in_valid || item_taken)
            begin
                if (tx_gap != 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end
                else if (token_queue.size() != 0)
                begin
                    tok = token_queue.pop_front();
                    operation <= tok.op;
                    push_value <= tok.value;
                    in_valid <= 1'b1;
                    tx_gap <= idle_len(tx_quiet);
                    if ($urandom_range(0, 49) == 0)
                    begin
                        tx_quiet <= !tx_quiet;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(
        input string             field,
        input logic [DATA_W-1:0] want,
        input logic [DATA_W-1:0] got
    );
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, $signed(want), $signed(got));
        end
    endtask

    // Monitor: checks each result taken against the oldest outstanding one and
    // stalls the result channel at random.
    always @(posedge clk)
    begin : result_monitor
        calc_result_t want;
        int unsigned  hold;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_hold <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: extra result, expected none, actual %0d %0d %0d",
                             $time, top_value, stack_empty, status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("top_value", want.top, top_value);
                    check_field("stack_empty", DATA_W'(want.empty), DATA_W'(stack_empty));
                    check_field("status", DATA_W'(want.stat), DATA_W'(status));
                end
                if ($urandom_range(0, 39) == 0)
                begin
                    rx_quiet <= !rx_quiet;
                end
            end
            if (rx_hold != 0)
            begin
                out_stall <= 1'b1;
                rx_hold <= rx_hold - 1;
            end
            else
            begin
                hold = idle_len(rx_quiet);
                out_stall <= (hold != 0);
                rx_hold <= (hold == 0) ? 0 : hold - 1;
            end
        end
    end

    // Watchdog: a run in which neither channel moves for too long has hung.
    always @(posedge clk)
    begin : hang_watchdog
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                timed_out <= 1'b1;
            end
        end
    end

    initial
    begin : run_control
        int       random_count;
        int       pick;
        op_code_t op;

        // Directed part. On the empty stack: a binary operator and negate underflow,
        // and the spare codes report an empty stack with status ok.
        queue_token(OP_ADD, MOST_POS);
        queue_token(OP_NEG, MOST_NEG);
        queue_token(OP_SPARE_LO, MINUS_ONE);
        queue_token(OP_SPARE_HI, '0);

        // Fill the stack to the brim, then push once more to see the overflow.
        // The upper entries are laid out so that the operators below meet the
        // special cases in turn.
        queue_token(OP_PUSH, 32'h5555_5555);
        queue_token(OP_PUSH, 32'hAAAA_AAAA);
        queue_token(OP_PUSH, 32'd1);
        queue_token(OP_PUSH, 32'd2);
        queue_token(OP_PUSH, 32'd100);
        queue_token(OP_PUSH, -32'sd100);
        queue_token(OP_PUSH, 32'h0001_0000);
        queue_token(OP_PUSH, 32'd3);
        queue_token(OP_PUSH, 32'd12345);
        queue_token(OP_PUSH, 32'd7);
        queue_token(OP_PUSH, -32'sd2);
        queue_token(OP_PUSH, MOST_POS);
        queue_token(OP_PUSH, 32'd1);
        queue_token(OP_PUSH, MOST_NEG);
        queue_token(OP_PUSH, MINUS_ONE);
        queue_token(OP_PUSH, '0);
        queue_token(OP_PUSH, 32'h1234_5678);

        // Zero on top: the divide is refused. Adding it away leaves the most
        // negative value over minus one, which wraps; negating that wraps too.
        // The subtract and add then wrap across both ends of the range.
        queue_token(OP_DIV, '0);
        queue_token(OP_ADD, '0);
        queue_token(OP_DIV, '0);
        queue_token(OP_NEG, '0);
        queue_token(OP_SUB, '0);
        queue_token(OP_ADD, '0);
        queue_token(OP_MUL, '0);
        queue_token(OP_DIV, '0);

        // Random part. Mostly well-formed expressions that keep the stack between
        // empty and full, with occasional runs to the top and down to the bottom,
        // some deliberate zero divisors and a share of arbitrary tokens.
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
            begin
                while (est_depth < CALC_DEPTH)
                begin
                    queue_token(OP_PUSH, random_operand());
                    random_count++;
                end
                queue_token(OP_PUSH, random_operand());
                random_count++;
            end
            else if (pick < 4)
            begin
                while (est_depth > 1)
                begin
                    queue_token(random_binary_op(), $urandom);
                    random_count++;
                end
                queue_token(random_binary_op(), $urandom);
                random_count++;
            end
            else if (pick < 9)
            begin
                queue_token(op_code_t'($urandom_range(0, 7)), $urandom);
                random_count++;
            end
            else if (est_depth < 2 || (est_depth < CALC_DEPTH && pick < 50))
            begin
                queue_token(OP_PUSH, random_operand());
                random_count++;
            end
            else if (pick < 58)
            begin
                queue_token(OP_NEG, $urandom);
                random_count++;
            end
            else
            begin
                op = random_binary_op();
                if (op == OP_DIV && $urandom_range(0, 7) == 0)
                begin
                    queue_token(OP_PUSH, '0);
                    random_count++;
                end
                queue_token(op, $urandom);
                random_count++;
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (!timed_out
               && (token_queue.size() != 0 || in_valid || expected_results.size() != 0))
        begin
            @(posedge clk);
        end
        // Give a stray extra result the chance to show up before the verdict.
        if (!timed_out)
        begin
            repeat (TAIL_CYCLES) @(posedge clk);
        end
        if (expected_results.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d results still outstanding, expected 0, actual %0d",
                     $time, expected_results.size(), expected_results.size());
        end

        if (!timed_out && mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
